// ----- hw/rtl/dsf_pkg.sv -----
// Package for the damped spring force pipeline.
// Holds field widths, register indexes, reset values and cell side-band widths.
// No dependencies.
`default_nettype none

package dsf_pkg;

    // Input component and difference widths (Q7.12 components, Q8.12 differences)
    localparam int COMP_W    = 20;
    localparam int VEC_W     = 3 * COMP_W;
    localparam int DIFF_W    = COMP_W + 1;
    localparam int LVEC_W    = 3 * DIFF_W;
    localparam int LSQ_W     = 2 * DIFF_W;
    localparam int DOT_W     = 2 * DIFF_W + 1;
    localparam int ROOT_W    = DIFF_W;
    localparam int REST_W    = 19;
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 12;

    // Force path widths
    localparam int TL_W      = 39;
    localparam int P1_W      = 59;
    localparam int Q1_W      = 39;
    localparam int S_W       = 40;
    localparam int P2_W      = 61;
    localparam int Q2_W      = 29;
    localparam int DEN_W     = ROOT_W + FRAC_W;
    localparam int F_W       = Q2_W + 1;
    localparam int FORCE_W   = 24;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = CFG_IDX_W'(1);
    localparam logic signed [COEF_W-1:0] STIFFNESS_RST = 16'sd2048;
    localparam logic signed [COEF_W-1:0] DAMPING_RST   = -16'sd1024;

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    // Side-band widths carried through the cell chains
    localparam int SQRT_SW   = LVEC_W + REST_W + DOT_W + 1;
    localparam int DIV1_SW   = LVEC_W + TL_W + 2;
    localparam int DIV2_SW   = 2;

    localparam int BIT_DEF   = 0;
    localparam int SW_DEF    = 1;

endpackage

`default_nettype wire

// ----- hw/rtl/damped_spring_force_top.sv -----
// Damped spring force: spring endpoints in, saturated force on the first endpoint out.
// Built from dsf_sqrt_cell and dsf_div_cell chains; depends on dsf_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one spring per beat: two positions,
//   two velocities and a rest length. Output channel (o_valid / i_stall) gives
//   one beat per spring: three force components plus zero_length and saturated.
//   Stiffness (index 0) and damping (index 1) are written on the cfg channel,
//   which is always ready; write them only while no spring is in flight.
// Pipeline:
//   An accepted spring passes through 96 register stages in all: three front
//   stages, 21 square root cells, one coefficient multiply stage, 39 cells of
//   the damping divider, two stages for the sum and axis products, 29 cells of
//   the three-lane force divider, then the output register. One spring is taken
//   every cycle while o_stall is low.
// Reset: i_rst_n low clears the in-flight valid bits and the output valid bit and
//   loads stiffness 0.5 and damping -0.25.
// Stall: a waiting result sits in the output register; the chain keeps moving
//   until a valid spring reaches its last stage, then freezes and raises o_stall.
`default_nettype none

module damped_spring_force_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire [dsf_pkg::VEC_W-1:0]             i_pos_a,
    input  wire [dsf_pkg::VEC_W-1:0]             i_pos_b,
    input  wire [dsf_pkg::VEC_W-1:0]             i_vel_a,
    input  wire [dsf_pkg::VEC_W-1:0]             i_vel_b,
    input  wire [dsf_pkg::REST_W-1:0]            i_rest_length,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [dsf_pkg::FORCE_W-1:0]   o_force_x,
    output logic signed [dsf_pkg::FORCE_W-1:0]   o_force_y,
    output logic signed [dsf_pkg::FORCE_W-1:0]   o_force_z,
    output logic                                 o_zero_length,
    output logic                                 o_saturated,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [dsf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [dsf_pkg::COEF_W-1:0]            i_cfg_data
);

    localparam int COMP_W  = dsf_pkg::COMP_W;
    localparam int DIFF_W  = dsf_pkg::DIFF_W;
    localparam int LVEC_W  = dsf_pkg::LVEC_W;
    localparam int LSQ_W   = dsf_pkg::LSQ_W;
    localparam int DOT_W   = dsf_pkg::DOT_W;
    localparam int ROOT_W  = dsf_pkg::ROOT_W;
    localparam int REST_W  = dsf_pkg::REST_W;
    localparam int COEF_W  = dsf_pkg::COEF_W;
    localparam int FRAC_W  = dsf_pkg::FRAC_W;
    localparam int TL_W    = dsf_pkg::TL_W;
    localparam int P1_W    = dsf_pkg::P1_W;
    localparam int Q1_W    = dsf_pkg::Q1_W;
    localparam int S_W     = dsf_pkg::S_W;
    localparam int P2_W    = dsf_pkg::P2_W;
    localparam int Q2_W    = dsf_pkg::Q2_W;
    localparam int DEN_W   = dsf_pkg::DEN_W;
    localparam int F_W     = dsf_pkg::F_W;
    localparam int FORCE_W = dsf_pkg::FORCE_W;
    localparam int SQ_SW   = dsf_pkg::SQRT_SW;
    localparam int D1_SW   = dsf_pkg::DIV1_SW;
    localparam int D2_SW   = dsf_pkg::DIV2_SW;
    localparam int NSTG    = 3 + ROOT_W + 1 + Q1_W + 2 + Q2_W;

    // ---------------- configuration ----------------
    logic signed [COEF_W-1:0] r_stiffness;
    logic signed [COEF_W-1:0] r_damping;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= dsf_pkg::STIFFNESS_RST;
            r_damping   <= dsf_pkg::DAMPING_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dsf_pkg::REG_STIFFNESS: r_stiffness <= i_cfg_data;
                dsf_pkg::REG_DAMPING:   r_damping   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic            w_en;
    logic            w_take_out;
    logic [NSTG-1:0] r_vld;
    logic            r_out_valid;

    assign w_take_out = !r_out_valid || !i_stall;
    // freeze only when a valid beat sits at the tail and cannot move on
    assign w_en       = w_take_out || !r_vld[NSTG-1];
    assign o_stall    = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [DIFF_W-1:0] n1_l   [3];
    logic signed [DIFF_W-1:0] n1_rel [3];
    logic signed [DIFF_W-1:0] r1_l   [3];
    logic signed [DIFF_W-1:0] r1_rel [3];
    logic [REST_W-1:0]        r1_rest;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_l[k]   = DIFF_W'($signed(i_pos_a[k*COMP_W +: COMP_W]))
                      - DIFF_W'($signed(i_pos_b[k*COMP_W +: COMP_W]));
            n1_rel[k] = DIFF_W'($signed(i_vel_a[k*COMP_W +: COMP_W]))
                      - DIFF_W'($signed(i_vel_b[k*COMP_W +: COMP_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_l    <= n1_l;
            r1_rel  <= n1_rel;
            r1_rest <= i_rest_length;
        end
    end

    // ---------------- stage 2: squares and products ----------------
    logic signed [LSQ_W-1:0]  r2_sq [3];
    logic signed [LSQ_W-1:0]  r2_pr [3];
    logic signed [DIFF_W-1:0] r2_l  [3];
    logic [REST_W-1:0]        r2_rest;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_sq[k] <= LSQ_W'(r1_l[k]) * LSQ_W'(r1_l[k]);
                r2_pr[k] <= LSQ_W'(r1_rel[k]) * LSQ_W'(r1_l[k]);
            end
            r2_l    <= r1_l;
            r2_rest <= r1_rest;
        end
    end

    // ---------------- stage 3: length squared and dot product ----------------
    logic [LSQ_W-1:0]        n3_lsq;
    logic signed [DOT_W-1:0] n3_dot;
    logic [LSQ_W-1:0]        r3_lsq;
    logic signed [DOT_W-1:0] r3_dot;
    logic                    r3_zero;
    logic [LVEC_W-1:0]       r3_lvec;
    logic [REST_W-1:0]       r3_rest;

    assign n3_lsq = $unsigned(r2_sq[0]) + $unsigned(r2_sq[1]) + $unsigned(r2_sq[2]);
    assign n3_dot = DOT_W'(r2_pr[0]) + DOT_W'(r2_pr[1]) + DOT_W'(r2_pr[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_lsq  <= n3_lsq;
            r3_dot  <= n3_dot;
            r3_zero <= (n3_lsq == '0);
            r3_lvec <= {r2_l[2], r2_l[1], r2_l[0]};
            r3_rest <= r2_rest;
        end
    end

    // ---------------- square root chain ----------------
    logic [LSQ_W-1:0]  w_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_sq_root [ROOT_W+1];
    logic [SQ_SW-1:0]  w_sq_side [ROOT_W+1];

    assign w_sq_rem[0]  = r3_lsq;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = {r3_lvec, r3_rest, r3_dot, r3_zero};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        dsf_sqrt_cell #(
            .BIT (ROOT_W - 1 - g),
            .SW  (SQ_SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_sq_rem[g]),
            .i_root (w_sq_root[g]),
            .i_side (w_sq_side[g]),
            .o_rem  (w_sq_rem[g+1]),
            .o_root (w_sq_root[g+1]),
            .o_side (w_sq_side[g+1])
        );
    end

    // ---------------- stage 4: coefficient products ----------------
    logic [ROOT_W-1:0]       w4_l;
    logic [LVEC_W-1:0]       w4_lvec;
    logic [REST_W-1:0]       w4_rest;
    logic signed [DOT_W-1:0] w4_dot;
    logic                    w4_zero;
    logic signed [ROOT_W:0]  n4_diff;
    logic signed [TL_W-1:0]  n4_tl;
    logic signed [P1_W-1:0]  n4_p;
    logic [P1_W-1:0]         r4_pmag;
    logic [ROOT_W-1:0]       r4_l;
    logic [D1_SW-1:0]        r4_side;

    assign w4_l    = w_sq_root[ROOT_W];
    assign w4_lvec = w_sq_side[ROOT_W][SQ_SW-1 -: LVEC_W];
    assign w4_rest = w_sq_side[ROOT_W][DOT_W+1 +: REST_W];
    assign w4_dot  = $signed(w_sq_side[ROOT_W][1 +: DOT_W]);
    assign w4_zero = w_sq_side[ROOT_W][0];

    assign n4_diff = $signed({1'b0, w4_l}) - $signed({{(ROOT_W+1-REST_W){1'b0}}, w4_rest});
    assign n4_tl   = -(TL_W'(r_stiffness) * TL_W'(n4_diff));
    assign n4_p    = P1_W'(r_damping) * P1_W'(w4_dot);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pmag <= n4_p[P1_W-1] ? $unsigned(-n4_p) : $unsigned(n4_p);
            r4_l    <= w4_l;
            r4_side <= {w4_lvec, n4_tl, n4_p[P1_W-1], w4_zero};
        end
    end

    // ---------------- damping divider chain ----------------
    logic [P1_W-1:0]   w_d1_rem  [Q1_W+1];
    logic [Q1_W-1:0]   w_d1_quo  [Q1_W+1];
    logic [ROOT_W-1:0] w_d1_div  [Q1_W+1];
    logic [D1_SW-1:0]  w_d1_side [Q1_W+1];

    assign w_d1_rem[0]  = r4_pmag;
    assign w_d1_quo[0]  = '0;
    assign w_d1_div[0]  = r4_l;
    assign w_d1_side[0] = r4_side;

    for (genvar g = 0; g < Q1_W; g++) begin : g_div1
        dsf_div_cell #(
            .BIT (Q1_W - 1 - g),
            .DW  (P1_W),
            .VW  (ROOT_W),
            .QW  (Q1_W),
            .SW  (D1_SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_d1_rem[g]),
            .i_quo  (w_d1_quo[g]),
            .i_div  (w_d1_div[g]),
            .i_side (w_d1_side[g]),
            .o_rem  (w_d1_rem[g+1]),
            .o_quo  (w_d1_quo[g+1]),
            .o_div  (w_d1_div[g+1]),
            .o_side (w_d1_side[g+1])
        );
    end

    // ---------------- stage 5: scalar force ----------------
    logic signed [TL_W-1:0] w5_tl;
    logic                   w5_psign;
    logic signed [S_W-1:0]  n5_tr;
    logic signed [S_W-1:0]  r5_s;
    logic [LVEC_W-1:0]      r5_lvec;
    logic [ROOT_W-1:0]      r5_l;
    logic                   r5_zero;

    assign w5_tl    = $signed(w_d1_side[Q1_W][2 +: TL_W]);
    assign w5_psign = w_d1_side[Q1_W][1];
    // truncate toward zero: divide the magnitude, then restore the sign
    assign n5_tr    = w5_psign ? -$signed(S_W'(w_d1_quo[Q1_W]))
                               :  $signed(S_W'(w_d1_quo[Q1_W]));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_s    <= S_W'(w5_tl) + n5_tr;
            r5_lvec <= w_d1_side[Q1_W][D1_SW-1 -: LVEC_W];
            r5_l    <= w_d1_div[Q1_W];
            r5_zero <= w_d1_side[Q1_W][0];
        end
    end

    // ---------------- stage 6: axis products ----------------
    logic signed [P2_W-1:0] n6_prod [3];
    logic [P2_W-1:0]        r6_mag  [3];
    logic                   r6_sign [3];
    logic [ROOT_W-1:0]      r6_l;
    logic                   r6_zero;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n6_prod[k] = P2_W'(r5_s) * P2_W'($signed(r5_lvec[k*DIFF_W +: DIFF_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r6_mag[k]  <= n6_prod[k][P2_W-1] ? $unsigned(-n6_prod[k])
                                                 : $unsigned(n6_prod[k]);
                r6_sign[k] <= n6_prod[k][P2_W-1];
            end
            r6_l    <= r5_l;
            r6_zero <= r5_zero;
        end
    end

    // ---------------- force divider chain, one lane per axis ----------------
    logic [P2_W-1:0]  w_d2_rem  [3][Q2_W+1];
    logic [Q2_W-1:0]  w_d2_quo  [3][Q2_W+1];
    logic [DEN_W-1:0] w_d2_div  [3][Q2_W+1];
    logic [D2_SW-1:0] w_d2_side [3][Q2_W+1];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign w_d2_rem[k][0]  = r6_mag[k];
        assign w_d2_quo[k][0]  = '0;
        assign w_d2_div[k][0]  = {r6_l, {FRAC_W{1'b0}}};
        assign w_d2_side[k][0] = {r6_zero, r6_sign[k]};

        for (genvar g = 0; g < Q2_W; g++) begin : g_div2
            dsf_div_cell #(
                .BIT (Q2_W - 1 - g),
                .DW  (P2_W),
                .VW  (DEN_W),
                .QW  (Q2_W),
                .SW  (D2_SW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rem  (w_d2_rem[k][g]),
                .i_quo  (w_d2_quo[k][g]),
                .i_div  (w_d2_div[k][g]),
                .i_side (w_d2_side[k][g]),
                .o_rem  (w_d2_rem[k][g+1]),
                .o_quo  (w_d2_quo[k][g+1]),
                .o_div  (w_d2_div[k][g+1]),
                .o_side (w_d2_side[k][g+1])
            );
        end
    end

    // ---------------- output register: sign, saturate, zero length ----------------
    logic signed [F_W-1:0]     n_f     [3];
    logic signed [FORCE_W-1:0] n_force [3];
    logic [2:0]                n_clip;
    logic                      w_zero;
    logic signed [FORCE_W-1:0] r_force [3];
    logic                      r_zero;
    logic                      r_sat;

    assign w_zero = w_d2_side[0][Q2_W][1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_f[k] = w_d2_side[k][Q2_W][0] ? -$signed(F_W'(w_d2_quo[k][Q2_W]))
                                          :  $signed(F_W'(w_d2_quo[k][Q2_W]));
            if (n_f[k] > F_W'(dsf_pkg::FORCE_MAX)) begin
                n_force[k] = dsf_pkg::FORCE_MAX;
                n_clip[k]  = 1'b1;
            end else if (n_f[k] < F_W'(dsf_pkg::FORCE_MIN)) begin
                n_force[k] = dsf_pkg::FORCE_MIN;
                n_clip[k]  = 1'b1;
            end else begin
                n_force[k] = n_f[k][FORCE_W-1:0];
                n_clip[k]  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take_out) begin
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_out) begin
            if (w_zero) begin
                for (int k = 0; k < 3; k++) begin
                    r_force[k] <= '0;
                end
                r_zero <= 1'b1;
                r_sat  <= 1'b0;
            end else begin
                r_force <= n_force;
                r_zero  <= 1'b0;
                r_sat   <= |n_clip;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_force_x     = r_force[0];
    assign o_force_y     = r_force[1];
    assign o_force_z     = r_force[2];
    assign o_zero_length = r_zero;
    assign o_saturated   = r_sat;

endmodule

`default_nettype wire

// ----- hw/rtl/dsf_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cell.
// Depends on dsf_pkg for widths.
`default_nettype none

module dsf_sqrt_cell #(
    parameter int BIT = dsf_pkg::BIT_DEF,
    parameter int SW  = dsf_pkg::SQRT_SW
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [dsf_pkg::LSQ_W-1:0]     i_rem,
    input  wire [dsf_pkg::ROOT_W-1:0]    i_root,
    input  wire [SW-1:0]                 i_side,
    output logic [dsf_pkg::LSQ_W-1:0]    o_rem,
    output logic [dsf_pkg::ROOT_W-1:0]   o_root,
    output logic [SW-1:0]                o_side
);

    localparam int LSQ_W  = dsf_pkg::LSQ_W;
    localparam int ROOT_W = dsf_pkg::ROOT_W;
    localparam int TW     = LSQ_W + 1;

    logic [TW-1:0]     w_trial;
    logic              w_take;
    logic [LSQ_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SW-1:0]     r_side;

    // (R + 2^b)^2 - R^2 = R*2^(b+1) + 2^(2b); R has no bits at or below b
    assign w_trial = (TW'(i_root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    assign w_take  = {1'b0, i_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_take) begin
                r_rem  <= i_rem - w_trial[LSQ_W-1:0];
                r_root <= i_root | (ROOT_W'(1) << BIT);
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

`default_nettype wire

// ----- hw/rtl/dsf_div_cell.sv -----
// One cell of a restoring divider chain: settles one quotient bit per cell.
// Depends on dsf_pkg for default widths.
`default_nettype none

module dsf_div_cell #(
    parameter int BIT = dsf_pkg::BIT_DEF,
    parameter int DW  = dsf_pkg::P1_W,
    parameter int VW  = dsf_pkg::ROOT_W,
    parameter int QW  = dsf_pkg::Q1_W,
    parameter int SW  = dsf_pkg::SW_DEF
) (
    input  wire           i_clk,
    input  wire           i_en,
    input  wire [DW-1:0]  i_rem,
    input  wire [QW-1:0]  i_quo,
    input  wire [VW-1:0]  i_div,
    input  wire [SW-1:0]  i_side,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_quo,
    output logic [VW-1:0] o_div,
    output logic [SW-1:0] o_side
);

    localparam int EW = (DW > VW + QW) ? DW : VW + QW;

    logic [EW-1:0] w_sub;
    logic          w_take;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [SW-1:0] r_side;

    assign w_sub  = EW'(i_div) << BIT;
    assign w_take = EW'(i_rem) >= w_sub;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_take) begin
                r_rem <= i_rem - w_sub[DW-1:0];
                r_quo <= i_quo | (QW'(1) << BIT);
            end else begin
                r_rem <= i_rem;
                r_quo <= i_quo;
            end
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

`default_nettype wire
